// ----- design/ttb_pkg.sv -----
// ----------------------------------------------------------------------------
// ttb_pkg
// shared constants, controller states and command/status words for the
// triangle tangent basis unit
// ----------------------------------------------------------------------------
package ttb_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int UV_WIDTH_DEF    = 16;
    localparam int UV_FRAC         = 12;
    localparam int OUT_WIDTH       = 32;
    localparam int DIV_CNT_W       = $clog2(OUT_WIDTH);
    localparam int COMP_W          = 3;

    typedef logic [COMP_W-1:0] comp_t;

    // component codes: determinant, then tangent xyz, then bitangent xyz
    localparam comp_t COMP_DET   = comp_t'(0);
    localparam comp_t COMP_TAN_X = comp_t'(1);
    localparam comp_t COMP_BIT_X = comp_t'(4);
    localparam comp_t COMP_LAST  = comp_t'(6);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MUL0  = 8'b0000_0010,
        S_MUL1  = 8'b0000_0100,
        S_ACC   = 8'b0000_1000,
        S_PREP  = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_ROUND = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic  hold_wr;
        logic  hold_sel;
        logic  edge_ld;
        logic  mul_en;
        logic  mul_j;
        logic  acc_ld;
        logic  acc_sub;
        logic  det_ld;
        logic  degen_set;
        logic  div_init;
        logic  sat_wr;
        logic  div_step;
        logic  round_wr;
        logic  out_ld;
        comp_t comp;
    } cmd_t;

    typedef struct packed {
        logic acc_zero;
        logic ovf;
        logic out_busy;
    } stat_t;

endpackage

// ----- design/ttb_vertex_if.sv -----
// ----------------------------------------------------------------------------
// ttb_vertex_if
// vertex channel: position, texture coordinate and mesh end marker
// ----------------------------------------------------------------------------
interface ttb_vertex_if #(
    parameter int COORD_WIDTH = ttb_pkg::COORD_WIDTH_DEF,
    parameter int UV_WIDTH    = ttb_pkg::UV_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;
    logic signed [UV_WIDTH-1:0]    tex_u;
    logic signed [UV_WIDTH-1:0]    tex_v;
    logic                          mesh_end;

    modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, mesh_end,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, mesh_end,
                    output ready);
endinterface

// ----- design/ttb_result_if.sv -----
// ----------------------------------------------------------------------------
// ttb_result_if
// result channel: tangent, bitangent and flags of one triangle
// ----------------------------------------------------------------------------
interface ttb_result_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ttb_pkg::OUT_WIDTH-1:0] tangent_x;
    logic signed [ttb_pkg::OUT_WIDTH-1:0] tangent_y;
    logic signed [ttb_pkg::OUT_WIDTH-1:0] tangent_z;
    logic signed [ttb_pkg::OUT_WIDTH-1:0] bitangent_x;
    logic signed [ttb_pkg::OUT_WIDTH-1:0] bitangent_y;
    logic signed [ttb_pkg::OUT_WIDTH-1:0] bitangent_z;
    logic                                 degenerate;
    logic                                 clipped;

    modport source (output valid, tangent_x, tangent_y, tangent_z, bitangent_x,
                    bitangent_y, bitangent_z, degenerate, clipped, input ready);
    modport sink   (input valid, tangent_x, tangent_y, tangent_z, bitangent_x,
                    bitangent_y, bitangent_z, degenerate, clipped, output ready);
endinterface

// ----- design/ttb_controller.sv -----
// ----------------------------------------------------------------------------
// ttb_controller
// vertex slot tracking and the sequencer for products and division steps
// ----------------------------------------------------------------------------
module ttb_controller (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_mesh_end,
    output logic           in_ready,
    input  ttb_pkg::stat_t stat,
    output ttb_pkg::cmd_t  cmd
);

    localparam logic [ttb_pkg::DIV_CNT_W-1:0] CNT_LAST =
        ttb_pkg::DIV_CNT_W'(ttb_pkg::OUT_WIDTH - 1);

    ttb_pkg::state_t                 state_reg, state_next;
    logic [1:0]                      slot_reg, slot_next;
    ttb_pkg::comp_t                  comp_reg, comp_next;
    logic [ttb_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ttb_pkg::S_IDLE;
            slot_reg  <= 2'd0;
            comp_reg  <= ttb_pkg::COMP_DET;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            comp_reg  <= comp_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.comp   = comp_reg;
        in_ready   = 1'b0;
        state_next = state_reg;
        slot_next  = slot_reg;
        comp_next  = comp_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ttb_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (slot_reg == 2'd0 || slot_reg == 2'd1)
                    begin
                        cmd.hold_wr  = 1'b1;
                        cmd.hold_sel = slot_reg[0];
                        slot_next    = in_mesh_end ? 2'd0 : slot_reg + 2'd1;
                    end
                    else
                    begin
                        cmd.edge_ld = 1'b1;
                        slot_next   = 2'd0;
                        comp_next   = ttb_pkg::COMP_DET;
                        state_next  = ttb_pkg::S_MUL0;
                    end
                end
            end
            ttb_pkg::S_MUL0:
            begin
                cmd.mul_en = 1'b1;
                state_next = ttb_pkg::S_MUL1;
            end
            ttb_pkg::S_MUL1:
            begin
                cmd.acc_ld = 1'b1;
                cmd.mul_en = 1'b1;
                cmd.mul_j  = 1'b1;
                state_next = ttb_pkg::S_ACC;
            end
            ttb_pkg::S_ACC:
            begin
                cmd.acc_sub = 1'b1;
                state_next  = ttb_pkg::S_PREP;
            end
            ttb_pkg::S_PREP:
            begin
                priority if (comp_reg == ttb_pkg::COMP_DET)
                begin
                    cmd.det_ld = 1'b1;
                    if (stat.acc_zero)
                    begin
                        cmd.degen_set = 1'b1;
                        state_next    = ttb_pkg::S_DONE;
                    end
                    else
                    begin
                        comp_next  = ttb_pkg::COMP_TAN_X;
                        state_next = ttb_pkg::S_MUL0;
                    end
                end
                else if (stat.ovf)
                begin
                    // quotient cannot fit, saturate without dividing
                    cmd.sat_wr = 1'b1;
                    if (comp_reg == ttb_pkg::COMP_LAST)
                        state_next = ttb_pkg::S_DONE;
                    else
                    begin
                        comp_next  = comp_reg + ttb_pkg::comp_t'(1);
                        state_next = ttb_pkg::S_MUL0;
                    end
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = ttb_pkg::S_DIV;
                end
            end
            ttb_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                    state_next = ttb_pkg::S_ROUND;
            end
            ttb_pkg::S_ROUND:
            begin
                cmd.round_wr = 1'b1;
                if (comp_reg == ttb_pkg::COMP_LAST)
                    state_next = ttb_pkg::S_DONE;
                else
                begin
                    comp_next  = comp_reg + ttb_pkg::comp_t'(1);
                    state_next = ttb_pkg::S_MUL0;
                end
            end
            ttb_pkg::S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_ld = 1'b1;
                    state_next = ttb_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ttb_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- design/ttb_datapath.sv -----
// ----------------------------------------------------------------------------
// ttb_datapath
// held vertices, edge deltas, shared multiplier with accumulator, restoring
// divider with rounding and saturation, result staging and output register
// ----------------------------------------------------------------------------
module ttb_datapath #(
    parameter int COORD_WIDTH = ttb_pkg::COORD_WIDTH_DEF,
    parameter int UV_WIDTH    = ttb_pkg::UV_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    ttb_vertex_if.sink     vtx,
    ttb_result_if.source   res,
    input  ttb_pkg::cmd_t  cmd,
    output ttb_pkg::stat_t stat
);

    localparam int OW   = ttb_pkg::OUT_WIDTH;
    localparam int CW   = COORD_WIDTH;
    localparam int UVD  = UV_WIDTH + 1;
    localparam int AW   = ((COORD_WIDTH > UV_WIDTH) ? COORD_WIDTH : UV_WIDTH) + 1;
    localparam int PW   = AW + UVD;
    localparam int ACCW = PW + 1;
    localparam int NW   = ACCW + ttb_pkg::UV_FRAC;
    localparam int DW   = 2 * UVD + 1;
    localparam int XW   = (NW > DW + OW) ? NW : DW + OW;

    localparam logic [OW-1:0] POS_MAX = {1'b0, {(OW-1){1'b1}}};
    localparam logic [OW-1:0] NEG_MIN = ~POS_MAX;

    // held vertices 0 and 1
    logic signed [CW-1:0]       pos_reg [2][3];
    logic signed [UV_WIDTH-1:0] uv_reg  [2][2];

    logic signed [CW:0]    e1_reg [3];
    logic signed [CW:0]    e2_reg [3];
    logic signed [UVD-1:0] a1_reg, b1_reg, a2_reg, b2_reg;

    logic signed [PW-1:0]   prod_reg;
    logic signed [ACCW-1:0] acc_reg;
    logic [DW-1:0]          d_reg;
    logic                   det_neg_reg;
    logic                   neg_reg;
    logic [DW-1:0]          rem_reg;
    logic [OW-1:0]          qsh_reg;
    logic                   degen_reg, clip_reg;
    logic [OW-1:0]          stage_reg [6];

    logic                   out_valid_reg;
    logic [OW-1:0]          out_reg [6];
    logic                   out_degen_reg, out_clip_reg;

    logic signed [CW-1:0]   in_pos [3];
    logic [1:0]             axis;
    logic signed [AW-1:0]   op_a;
    logic signed [UVD-1:0]  op_b;
    logic signed [PW-1:0]   prod_c;
    logic [ACCW-1:0]        acc_mag;
    logic [XW-1:0]          n_ext, d_ext;
    logic                   neg_c;
    logic [DW:0]            div_t, div_d;
    logic                   div_ge;
    logic [DW:0]            div_diff;
    logic                   rbit;
    logic [OW:0]            mag, lim;
    logic                   rclip;
    logic [OW-1:0]          rval, rres, sat_val;
    logic [2:0]             widx;

    assign in_pos[0] = vtx.pos_x;
    assign in_pos[1] = vtx.pos_y;
    assign in_pos[2] = vtx.pos_z;

    // operand selection for the shared multiplier
    always_comb
    begin
        axis = 2'd0;
        if (cmd.comp >= ttb_pkg::COMP_BIT_X)
            axis = 2'(cmd.comp - ttb_pkg::COMP_BIT_X);
        else if (cmd.comp >= ttb_pkg::COMP_TAN_X)
            axis = 2'(cmd.comp - ttb_pkg::COMP_TAN_X);
        priority if (cmd.comp == ttb_pkg::COMP_DET)
        begin
            op_a = cmd.mul_j ? AW'(b1_reg) : AW'(a1_reg);
            op_b = cmd.mul_j ? a2_reg : b2_reg;
        end
        else if (cmd.comp < ttb_pkg::COMP_BIT_X)
        begin
            op_a = cmd.mul_j ? AW'(e2_reg[axis]) : AW'(e1_reg[axis]);
            op_b = cmd.mul_j ? b1_reg : b2_reg;
        end
        else
        begin
            op_a = cmd.mul_j ? AW'(e1_reg[axis]) : AW'(e2_reg[axis]);
            op_b = cmd.mul_j ? a2_reg : a1_reg;
        end
    end

    assign prod_c  = PW'(op_a) * PW'(op_b);
    assign acc_mag = acc_reg[ACCW-1] ? ACCW'(-acc_reg) : ACCW'(acc_reg);
    assign n_ext   = XW'({acc_mag, {ttb_pkg::UV_FRAC{1'b0}}});
    assign d_ext   = XW'(d_reg) << OW;
    assign neg_c   = acc_reg[ACCW-1] ^ det_neg_reg;
    assign sat_val = neg_c ? NEG_MIN : POS_MAX;

    // one restoring step
    assign div_t    = {rem_reg, qsh_reg[OW-1]};
    assign div_d    = {1'b0, d_reg};
    assign div_ge   = div_t >= div_d;
    assign div_diff = div_t - div_d;

    // round half away from zero on magnitude, then clamp
    assign rbit  = {rem_reg, 1'b0} >= div_d;
    assign mag   = {1'b0, qsh_reg} + (OW+1)'(rbit);
    assign lim   = neg_reg ? {1'b0, NEG_MIN} : {1'b0, POS_MAX};
    assign rclip = mag > lim;
    assign rval  = rclip ? lim[OW-1:0] : mag[OW-1:0];
    assign rres  = neg_reg ? -rval : rval;

    assign widx = 3'(cmd.comp - ttb_pkg::COMP_TAN_X);

    assign stat.acc_zero = (acc_reg == '0);
    assign stat.ovf      = (n_ext >= d_ext);
    assign stat.out_busy = out_valid_reg && !res.ready;

    always_ff @(posedge clk)
    begin
        if (cmd.hold_wr)
        begin
            for (int i = 0; i < 3; i++)
                pos_reg[cmd.hold_sel][i] <= in_pos[i];
            uv_reg[cmd.hold_sel][0] <= vtx.tex_u;
            uv_reg[cmd.hold_sel][1] <= vtx.tex_v;
        end
        if (cmd.edge_ld)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e1_reg[i] <= (CW+1)'(pos_reg[1][i]) - (CW+1)'(pos_reg[0][i]);
                e2_reg[i] <= (CW+1)'(in_pos[i]) - (CW+1)'(pos_reg[0][i]);
            end
            a1_reg <= UVD'(uv_reg[1][0]) - UVD'(uv_reg[0][0]);
            b1_reg <= UVD'(uv_reg[1][1]) - UVD'(uv_reg[0][1]);
            a2_reg <= UVD'(vtx.tex_u) - UVD'(uv_reg[0][0]);
            b2_reg <= UVD'(vtx.tex_v) - UVD'(uv_reg[0][1]);
        end
        if (cmd.mul_en)
            prod_reg <= prod_c;
        if (cmd.acc_ld)
            acc_reg <= ACCW'(prod_reg);
        else if (cmd.acc_sub)
            acc_reg <= acc_reg - ACCW'(prod_reg);
        if (cmd.det_ld)
        begin
            d_reg       <= acc_mag[DW-1:0];
            det_neg_reg <= acc_reg[ACCW-1];
        end
        if (cmd.div_init)
        begin
            rem_reg <= n_ext[OW +: DW];
            qsh_reg <= n_ext[OW-1:0];
            neg_reg <= neg_c;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= div_ge ? div_diff[DW-1:0] : div_t[DW-1:0];
            qsh_reg <= {qsh_reg[OW-2:0], div_ge};
        end
        if (cmd.sat_wr)
            stage_reg[widx] <= sat_val;
        else if (cmd.round_wr)
            stage_reg[widx] <= rres;
        if (cmd.out_ld)
        begin
            for (int i = 0; i < 6; i++)
                out_reg[i] <= degen_reg ? '0 : stage_reg[i];
            out_degen_reg <= degen_reg;
            out_clip_reg  <= clip_reg && !degen_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degen_reg     <= 1'b0;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.edge_ld)
            begin
                degen_reg <= 1'b0;
                clip_reg  <= 1'b0;
            end
            else
            begin
                if (cmd.degen_set)
                    degen_reg <= 1'b1;
                if (cmd.sat_wr || (cmd.round_wr && rclip))
                    clip_reg <= 1'b1;
            end
            if (cmd.out_ld)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.tangent_x   = out_reg[0];
    assign res.tangent_y   = out_reg[1];
    assign res.tangent_z   = out_reg[2];
    assign res.bitangent_x = out_reg[3];
    assign res.bitangent_y = out_reg[4];
    assign res.bitangent_z = out_reg[5];
    assign res.degenerate  = out_degen_reg;
    assign res.clipped     = out_clip_reg;

endmodule

// ----- design/triangle_tangent_basis_unit.sv -----
// ----------------------------------------------------------------------------
// triangle_tangent_basis_unit
// per-triangle tangent and bitangent from positions and texture coordinates
// ----------------------------------------------------------------------------
//  channel  dir  word                                         handshake
//  vtx      in   pos_x/y/z, tex_u/v, mesh_end                 valid/ready
//  res      out  tangent_x/y/z, bitangent_x/y/z, degenerate,  valid/ready
//                clipped
//
//  first and second vertex of a triangle: stored in the held vertex registers
//  third vertex: for the determinant and six components, two products on
//  the shared multiplier, then for each component the restoring divider
//  unless the quotient saturates; degenerate triangles stop at the determinant
//  a finished result waits in the output register; vertices of the next
//  triangle are taken meanwhile, its word then waits in the sequencer for
//  the output register before further vertices are taken
//  asynchronous active-low reset clears the slot counter and the sequencer
// ----------------------------------------------------------------------------
module triangle_tangent_basis_unit #(
    parameter int COORD_WIDTH = ttb_pkg::COORD_WIDTH_DEF,
    parameter int UV_WIDTH    = ttb_pkg::UV_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    ttb_vertex_if.sink   vtx,
    ttb_result_if.source res
);

    ttb_pkg::cmd_t  cmd;
    ttb_pkg::stat_t stat;
    logic           ready;

    ttb_controller u_ctl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (vtx.valid),
        .in_mesh_end (vtx.mesh_end),
        .in_ready    (ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    ttb_datapath #(
        .COORD_WIDTH (COORD_WIDTH),
        .UV_WIDTH    (UV_WIDTH)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .vtx   (vtx),
        .res   (res),
        .cmd   (cmd),
        .stat  (stat)
    );

    assign vtx.ready = ready;

    // a degenerate word carries zero vectors and no clip
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.degenerate |-> res.tangent_x == '0 && res.tangent_y == '0
            && res.tangent_z == '0 && res.bitangent_x == '0
            && res.bitangent_y == '0 && res.bitangent_z == '0 && !res.clipped)
        else $error("degenerate word with nonzero content");

    // output register never overwritten while a word waits
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_ld |-> !(res.valid && !res.ready))
        else $error("result overwritten before it was taken");

    // no vertex taken while the divider runs
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> !vtx.ready)
        else $error("vertex taken during division");

endmodule
